// ----- hdl/upq_pkg.sv -----
package upq_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_REMOVE  = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NOMATCH = 3'd2,
        ST_BADURG  = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_RESP
    } state_t;

    localparam int ID_W  = 16;
    localparam int ORG_W = 4;
    localparam int URG_W = 3;
    localparam int OCC_W = 6;

    localparam logic [URG_W-1:0] URG_MIN = 3'd1;
    localparam logic [URG_W-1:0] URG_MAX = 3'd5;

    // One stored entry of the queue.
    typedef struct packed {
        logic [URG_W-1:0] urg;
        logic [ORG_W-1:0] organ;
        logic [ID_W-1:0]  id;
    } entry_t;

endpackage

// ----- hdl/upq_ram.sv -----
module upq_ram
    import upq_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/urgency_priority_queue.sv -----
// Bounded priority queue of up to CAPACITY entries, kept in service order in an
// entry memory with one read and one write port (highest urgency first, first
// come first within a level). Each input item is one operation: enqueue, dequeue
// the first entry with a matching organ, or remove the first entry with a
// matching id; each item yields exactly one result item with status, the removed
// entry and the occupancy. The block handles one item at a time and holds
// s_tready low while it works. Every step of the search and of the shift that
// opens or closes a gap is one read of the entry memory followed by a compare or
// a write back. Rejected items (bad urgency, full, empty) and the unused code go
// straight to the result. A result that is not taken yet holds the sequencer in
// its last state. The memory needs no clearing after reset, since only entries
// below the count are ever used.
module urgency_priority_queue
    import upq_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: patient_id[15:0], organ_code[19:16], urgency[22:20], zero pad.
    input  logic [23:0] s_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: status[2:0], removed_id[18:3], removed_organ[22:19],
    // removed_urgency[25:23], occupancy[31:26].
    output logic [31:0] m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t           state_reg, state_next;
    func_t            func_reg, func_next;
    entry_t           req_reg, req_next;
    entry_t           rem_reg, rem_next;
    status_t          status_reg, status_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      m_tdata_reg, m_tdata_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    entry_t           ram_rdata;

    logic             in_fire;
    logic             cmp_hit;
    logic [CW-1:0]    ptr_dec;
    logic [CW-1:0]    ptr_inc;
    entry_t           in_entry;

    upq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_entry.id    = s_tdata[15:0];
    assign in_entry.organ = s_tdata[19:16];
    assign in_entry.urg   = s_tdata[22:20];

    assign ptr_dec = ptr_reg - CW'(1);
    assign ptr_inc = ptr_reg + CW'(1);

    // Shared compare unit: insertion point for enqueue, match for the others.
    always_comb
    begin
        case (func_reg)
            FUNC_ENQUEUE: cmp_hit = (ram_rdata.urg < req_reg.urg);
            FUNC_DEQUEUE: cmp_hit = (ram_rdata.organ == req_reg.organ);
            FUNC_REMOVE:  cmp_hit = (ram_rdata.id == req_reg.id);
            default:      cmp_hit = 1'b0;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        req_reg     <= req_next;
        rem_reg     <= rem_next;
        status_reg  <= status_next;
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Next state and memory control.
    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        req_next      = req_reg;
        rem_next      = rem_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = ptr_reg[AW-1:0];

        // The result leaves the output register when taken.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    func_next   = func_t'(s_tuser);
                    req_next    = in_entry;
                    rem_next    = '0;
                    status_next = ST_OK;
                    ptr_next    = '0;
                    state_next  = S_RESP;
                    case (func_t'(s_tuser))
                        FUNC_ENQUEUE:
                        begin
                            if (in_entry.urg < URG_MIN || in_entry.urg > URG_MAX)
                            begin
                                status_next = ST_BADURG;
                            end
                            else if (count_reg >= CAP_C)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        FUNC_DEQUEUE, FUNC_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Search: issue a read, or end at the tail.
            S_SCAN_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    if (func_reg == FUNC_ENQUEUE)
                    begin
                        pos_next   = ptr_reg;
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        status_next = ST_NOMATCH;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (cmp_hit)
                begin
                    pos_next = ptr_reg;
                    if (func_reg == FUNC_ENQUEUE)
                    begin
                        ptr_next   = count_reg;
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        rem_next   = ram_rdata;
                        ptr_next   = ptr_inc;
                        state_next = S_DN_RD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
            end

            // Open a gap at the insertion point, moving entries up from the tail.
            S_UP_RD:
            begin
                if (ptr_reg == pos_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = pos_reg[AW-1:0];
                    ram_wdata   = req_reg;
                    count_next  = count_reg + CW'(1);
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    ram_raddr  = ptr_dec[AW-1:0];
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg[AW-1:0];
                ptr_next   = ptr_dec;
                state_next = S_UP_RD;
            end

            // Close the gap left by a removed entry.
            S_DN_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_DN_WR;
                end
            end

            S_DN_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_dec[AW-1:0];
                ptr_next   = ptr_inc;
                state_next = S_DN_RD;
            end

            // Hand the result to the output register once it is free.
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {OCC_W'(count_reg), rem_reg.urg, rem_reg.organ,
                                     rem_reg.id, status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The entry count never goes past the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_C)
        else $error("entry count exceeds capacity");

    // The count moves only when an insertion or a removal completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UP_RD && state_reg != S_DN_RD) |=> $stable(count_reg))
        else $error("entry count changed outside an insert or remove");

    // A reported removal always carries an ok status and a legal urgency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[25:23] != 3'd0) |->
            (m_tdata[2:0] == ST_OK && m_tdata[25:23] <= URG_MAX))
        else $error("removed entry reported with bad status or urgency");

    // The memory is written only while an operation is shifting or inserting.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_UP_RD || state_reg == S_UP_WR || state_reg == S_DN_WR))
        else $error("entry memory written outside a shift");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top
    import upq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 200;

    // One request as the sender presents it, with its lead-in gap.
    typedef struct {
        func_t            func;
        logic [ID_W-1:0]  id;
        logic [ORG_W-1:0] organ;
        logic [URG_W-1:0] urg;
        int               gap;
        bit               wait_drain;
    } request_t;

    // One predicted response.
    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  id;
        logic [ORG_W-1:0] organ;
        logic [URG_W-1:0] urg;
        logic [OCC_W-1:0] occupancy;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // Fields from bit 0: patient_id[15:0], organ_code[19:16], urgency[22:20], zero pad.
    logic [23:0] s_tdata;
    // Fields from bit 0: func[1:0].
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // Fields from bit 0: status[2:0], removed_id[18:3], removed_organ[22:19],
    // removed_urgency[25:23], occupancy[31:26].
    logic [31:0] m_tdata;

    request_t          requests[$];
    outcome_t          awaited_outcomes[$];
    logic [ID_W-1:0]   held_ids[$];
    logic [ORG_W-1:0]  held_organs[$];
    logic [URG_W-1:0]  held_urgs[$];
    logic [ID_W-1:0]   issued_ids[$];

    int  mismatch_count;
    int  cycle_count;
    bit  in_fire;
    bit  out_fire;
    bit  sender_bursty;
    bit  receiver_bursty;
    bit  have_next;
    int  send_gap;
    int  recv_wait;
    request_t next_req;

    urgency_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock: 8 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic flag_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
    endtask

    // Applies one operation to the shadow store and returns the response it yields.
    function automatic outcome_t apply_operation(func_t f, logic [ID_W-1:0] pid,
                                                 logic [ORG_W-1:0] org,
                                                 logic [URG_W-1:0] u);
        outcome_t r;
        int       pos;
        bit       hit;
        r = '0;
        r.status = ST_OK;
        pos = 0;
        hit = 1'b0;
        case (f)
            FUNC_ENQUEUE:
            begin
                if (u < URG_MIN || u > URG_MAX)
                begin
                    r.status = ST_BADURG;
                end
                else if (held_urgs.size() >= QUEUE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // New entry goes behind every entry of equal or higher urgency.
                    while (pos < held_urgs.size() && held_urgs[pos] >= u)
                    begin
                        pos++;
                    end
                    held_ids.insert(pos, pid);
                    held_organs.insert(pos, org);
                    held_urgs.insert(pos, u);
                end
            end
            FUNC_DEQUEUE, FUNC_REMOVE:
            begin
                if (held_urgs.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // First match in service order wins.
                    while (!hit && pos < held_urgs.size())
                    begin
                        if ((f == FUNC_DEQUEUE) ? (held_organs[pos] == org)
                                                : (held_ids[pos] == pid))
                        begin
                            hit = 1'b1;
                        end
                        else
                        begin
                            pos++;
                        end
                    end
                    if (!hit)
                    begin
                        r.status = ST_NOMATCH;
                    end
                    else
                    begin
                        r.id    = held_ids[pos];
                        r.organ = held_organs[pos];
                        r.urg   = held_urgs[pos];
                        held_ids.delete(pos);
                        held_organs.delete(pos);
                        held_urgs.delete(pos);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(held_urgs.size());
        return r;
    endfunction

    // Queues one request; the lead-in gap follows the current sender mode.
    task automatic add_request(func_t f, logic [ID_W-1:0] pid, logic [ORG_W-1:0] org,
                               logic [URG_W-1:0] u, bit drain);
        request_t q;
        q.func       = f;
        q.id         = pid;
        q.organ      = org;
        q.urg        = u;
        q.gap        = sender_bursty ? 0 : $urandom_range(0, 19);
        q.wait_drain = drain;
        requests.push_back(q);
        if (f == FUNC_ENQUEUE)
        begin
            issued_ids.push_back(q.id);
        end
    endtask

    // Builds one random request leaning toward enqueue by the given percentage.
    task automatic add_random_request(int enq_pct, bit drain);
        int               roll;
        logic [ID_W-1:0]  pid;
        logic [URG_W-1:0] u;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct)
        begin
            u = URG_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 5)
                                                      : $urandom_range(0, 7));
            add_request(FUNC_ENQUEUE, ID_W'($urandom_range(0, 65535)),
                        ORG_W'($urandom_range(0, 15)), u, drain);
        end
        else if (roll < enq_pct + (100 - enq_pct) / 2)
        begin
            add_request(FUNC_DEQUEUE, ID_W'($urandom_range(0, 65535)),
                        ORG_W'($urandom_range(0, 15)), URG_W'($urandom_range(0, 7)), drain);
        end
        else if (roll < 97)
        begin
            // Mostly ids already issued, so that removals find their target.
            if (issued_ids.size() != 0 && $urandom_range(0, 99) < 70)
            begin
                pid = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
            end
            else
            begin
                pid = ID_W'($urandom_range(0, 65535));
            end
            add_request(FUNC_REMOVE, pid, ORG_W'($urandom_range(0, 15)),
                        URG_W'($urandom_range(0, 7)), drain);
        end
        else
        begin
            add_request(FUNC_NOP, ID_W'($urandom_range(0, 65535)),
                        ORG_W'($urandom_range(0, 15)), URG_W'($urandom_range(0, 7)), drain);
        end
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        int made;
        int seg_len;
        int enq_pct;
        int k;
        rst_n          = 1'b0;
        mismatch_count = 0;
        made           = 0;
        sender_bursty  = 1'b0;

        // Directed: empty store, unused code, bad urgencies, field extremes,
        // first come first within a level, hits and misses of both searches.
        add_request(FUNC_DEQUEUE, 16'h0000, 4'h0, 3'd1, 1'b0);
        add_request(FUNC_REMOVE,  16'h0000, 4'h0, 3'd1, 1'b0);
        add_request(FUNC_NOP,     16'hFFFF, 4'hF, 3'd7, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h1111, 4'h1, 3'd0, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h2222, 4'h2, 3'd6, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h3333, 4'h3, 3'd7, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h0000, 4'h0, 3'd1, 1'b0);
        add_request(FUNC_ENQUEUE, 16'hFFFF, 4'hF, 3'd5, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h1234, 4'h3, 3'd3, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h1235, 4'h3, 3'd3, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h00AA, 4'hF, 3'd5, 1'b0);
        add_request(FUNC_DEQUEUE, 16'h0000, 4'h3, 3'd0, 1'b0);
        add_request(FUNC_DEQUEUE, 16'h0000, 4'h7, 3'd0, 1'b0);
        add_request(FUNC_REMOVE,  16'hFFFF, 4'h0, 3'd0, 1'b0);
        add_request(FUNC_REMOVE,  16'h4321, 4'h0, 3'd0, 1'b0);
        add_request(FUNC_NOP,     16'h0000, 4'h0, 3'd0, 1'b0);
        add_request(FUNC_ENQUEUE, 16'h5555, 4'h5, 3'd7, 1'b0);
        add_request(FUNC_REMOVE,  16'h0000, 4'h0, 3'd0, 1'b0);
        add_request(FUNC_DEQUEUE, 16'h0000, 4'hF, 3'd0, 1'b0);
        add_request(FUNC_DEQUEUE, 16'h0000, 4'h3, 3'd0, 1'b0);
        add_request(FUNC_DEQUEUE, 16'h0000, 4'h0, 3'd0, 1'b0);

        // Random part in segments of differing mix; the first is 95 percent enqueues
        // and starts only once the directed responses are all in.
        k = 0;
        while (made < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(20, 60);
            case ((k == 0) ? 0 : $urandom_range(0, 2))
                0:       enq_pct = (k == 0) ? 95 : 75;
                1:       enq_pct = 25;
                default: enq_pct = 50;
            endcase
            sender_bursty = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg_len; i++)
            begin
                add_random_request(enq_pct, (i == 0) && (k == 0 || $urandom_range(0, 3) == 0));
            end
            made += seg_len;
            k++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (requests.size() != 0 || have_next || s_tvalid)
        begin
            @(posedge clk);
        end
        while (awaited_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Sender: presents requests at the falling edge, holding each until accepted.
    always @(negedge clk)
    begin
        bit tv;
        tv = s_tvalid;
        if (!rst_n)
        begin
            tv = 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            tv = 1'b0;
            if (!have_next && requests.size() != 0)
            begin
                next_req  = requests.pop_front();
                have_next = 1'b1;
                send_gap  = next_req.gap;
            end
            if (have_next)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (!(next_req.wait_drain && awaited_outcomes.size() != 0))
                begin
                    s_tdata   <= {1'b0, next_req.urg, next_req.organ, next_req.id};
                    s_tuser   <= next_req.func;
                    tv        = 1'b1;
                    have_next = 1'b0;
                end
            end
        end
        s_tvalid <= tv;
    end

    // Receiver: after each response, stalls a drawn number of cycles while a
    // response is on offer.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    receiver_bursty = !receiver_bursty;
                end
                recv_wait = receiver_bursty ? 0 : $urandom_range(0, 19);
            end
            if (recv_wait > 0)
            begin
                if (m_tvalid)
                begin
                    recv_wait--;
                end
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted response.
    always @(posedge clk)
    begin
        outcome_t want;
        in_fire  <= rst_n && s_tvalid && s_tready;
        out_fire <= rst_n && m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                flag_mismatch("response with none outstanding", m_tdata, 0);
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                if (m_tdata[2:0] != want.status)
                    flag_mismatch("status", m_tdata[2:0], want.status);
                if (m_tdata[18:3] != want.id)
                    flag_mismatch("removed_id", m_tdata[18:3], want.id);
                if (m_tdata[22:19] != want.organ)
                    flag_mismatch("removed_organ", m_tdata[22:19], want.organ);
                if (m_tdata[25:23] != want.urg)
                    flag_mismatch("removed_urgency", m_tdata[25:23], want.urg);
                if (m_tdata[31:26] != want.occupancy)
                    flag_mismatch("occupancy", m_tdata[31:26], want.occupancy);
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            awaited_outcomes.push_back(apply_operation(func_t'(s_tuser), s_tdata[15:0],
                                                       s_tdata[19:16], s_tdata[22:20]));
        end
    end

    // Initial values of the driven inputs and the bookkeeping flags.
    initial
    begin
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        in_fire         = 1'b0;
        out_fire        = 1'b0;
        have_next       = 1'b0;
        send_gap        = 0;
        recv_wait       = 0;
        receiver_bursty = 1'b0;
        cycle_count     = 0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
hdl/upq_pkg.sv
hdl/upq_ram.sv
hdl/urgency_priority_queue.sv
tb/sv/tb_top.sv
